FILE: rtl/sfrls_pkg.sv
// Shared types and constants for the SET-frame link set-up sender.
`timescale 1ns / 1ps

package sfrls_pkg;

   localparam logic [7:0] FRAME_FLAG = 8'h7e;
   localparam int         FRAME_LEN  = 5;
   localparam logic [2:0] LAST_BEAT  = 3'(FRAME_LEN - 1);
   localparam logic [2:0] RX_FULL    = 3'(FRAME_LEN);

   // request kinds
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_CHK = 2'd1;
   localparam logic [1:0] ST_GAVE_UP = 2'd2;

   // register indexes
   localparam logic [1:0] REG_TIMEOUT  = 2'd0;
   localparam logic [1:0] REG_MAX_ATT  = 2'd1;
   localparam logic [1:0] REG_ADDRESS  = 2'd2;
   localparam logic [1:0] REG_CONTROL  = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_RECV,
      PH_HOLD
   } phase_type;

   // one pending run of results: a full frame or a single status beat
   typedef struct packed {
      logic       valid;
      logic       frame;
      logic [1:0] code;
      logic [7:0] addr;
      logic [7:0] ctrl;
   } desc_type;

endpackage

FILE: rtl/set_frame_retry_link_setup.sv
// Link set-up sender: sends SET frames, checks the response, retries on timeout.
//
// Request channel (req_*): one beat per event; tuser carries the kind (start,
// received byte, timer tick) and tdata the received byte. Result channel
// (rsp_*): tuser is 0 for a byte to transmit and 1 for a status report,
// tdata carries the byte and the status code, tlast marks the final beat of
// the run caused by one request.
// Configuration (csr_*): write-only registers; the user must write them only
// while the block is idle, which the block itself does not enforce.
// Throughput: one request per cycle while req_tready is high. A start, or a
// tick that expires and resends, yields a five-beat frame on the result
// channel; a response flag or a final timeout yields one status beat; other
// requests yield nothing. The first result beat of a request is registered in
// the run descriptor register, then the result register. Requests keep flowing
// while a result waits: one run may queue in the descriptor register, and
// ready drops only while that register is full and the result register has
// not yet handed over the last beat of the run before it.
// Reset returns the block to idle; descriptor and result data are not reset.
`timescale 1ns / 1ps

module set_frame_retry_link_setup (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] tx_byte, [9:8] status_code, rest zero
   output logic        rsp_tlast,   // last_of_run
   output logic        rsp_tuser,   // [0] out_kind
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0] timeout_ff;
   logic [3:0] max_att_ff;
   logic [7:0] address_ff;
   logic [7:0] control_ff;

   sfrls_pkg::phase_type phase_ff, phase_in;
   logic [3:0] attempts_ff, attempts_in;
   logic [7:0] ticks_ff, ticks_in;
   logic [2:0] rxpos_ff, rxpos_in;
   // slot zero holds the opening flag and is never checked, so it is not kept
   logic [7:0] cap_ff [1:3];
   logic [7:0] cap_in [1:3];

   sfrls_pkg::desc_type desc_ff, desc_in;

   logic       out_valid_ff, out_valid_in;
   logic       out_frame_ff, out_frame_in;
   logic [2:0] beat_ff, beat_in;
   logic [7:0] tx_ff, tx_in;
   logic [1:0] code_ff, code_in;
   logic       last_ff, last_in;
   logic [7:0] oaddr_ff, oaddr_in;
   logic [7:0] octrl_ff, octrl_in;

   logic req_acc;
   logic desc_take;
   logic send;
   logic [2:0] beat_nx;

   assign desc_take  = desc_ff.valid && (!out_valid_ff || (rsp_tready && last_ff));
   assign req_tready = !desc_ff.valid || desc_take;
   assign req_acc    = req_tvalid && req_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 8'd3;
         max_att_ff <= 4'd3;
         address_ff <= 8'd3;
         control_ff <= 8'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            sfrls_pkg::REG_TIMEOUT: timeout_ff <= csr_wdata;
            sfrls_pkg::REG_MAX_ATT: max_att_ff <= csr_wdata[3:0];
            sfrls_pkg::REG_ADDRESS: address_ff <= csr_wdata;
            sfrls_pkg::REG_CONTROL: control_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // protocol state and run descriptor
   always_comb begin
      phase_in    = phase_ff;
      attempts_in = attempts_ff;
      ticks_in    = ticks_ff;
      rxpos_in    = rxpos_ff;
      cap_in      = cap_ff;
      desc_in     = desc_ff;
      send        = 1'b0;
      if (desc_take) begin
         desc_in.valid = 1'b0;
      end
      if (req_acc) begin
         unique case (req_tuser)
            sfrls_pkg::KIND_START: begin
               attempts_in = 4'd1;
               send        = 1'b1;
            end
            sfrls_pkg::KIND_BYTE: begin
               if (phase_ff == sfrls_pkg::PH_RECV) begin
                  if (req_tdata == sfrls_pkg::FRAME_FLAG && rxpos_ff != 3'd0) begin
                     desc_in.valid = 1'b1;
                     desc_in.frame = 1'b0;
                     if (cap_ff[3] == (cap_ff[1] ^ cap_ff[2])) begin
                        phase_in     = sfrls_pkg::PH_IDLE;
                        desc_in.code = sfrls_pkg::ST_OK;
                     end else begin
                        phase_in     = sfrls_pkg::PH_HOLD;
                        desc_in.code = sfrls_pkg::ST_BAD_CHK;
                     end
                  end else begin
                     if (rxpos_ff != 3'd0 && rxpos_ff < 3'd4) begin
                        cap_in[rxpos_ff[1:0]] = req_tdata;
                     end
                     // saturate: drop bytes past the fifth
                     if (rxpos_ff < sfrls_pkg::RX_FULL) begin
                        rxpos_in = rxpos_ff + 3'd1;
                     end
                  end
               end
            end
            sfrls_pkg::KIND_TICK: begin
               if (phase_ff != sfrls_pkg::PH_IDLE) begin
                  if (ticks_ff > 8'd1) begin
                     ticks_in = ticks_ff - 8'd1;
                  end else begin
                     ticks_in = 8'd0;
                     if (attempts_ff < max_att_ff) begin
                        attempts_in = attempts_ff + 4'd1;
                        send        = 1'b1;
                     end else begin
                        phase_in      = sfrls_pkg::PH_IDLE;
                        desc_in.valid = 1'b1;
                        desc_in.frame = 1'b0;
                        desc_in.code  = sfrls_pkg::ST_GAVE_UP;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (send) begin
         ticks_in      = timeout_ff;
         rxpos_in      = 3'd0;
         cap_in[1]     = 8'd0;
         cap_in[2]     = 8'd0;
         cap_in[3]     = 8'd0;
         phase_in      = sfrls_pkg::PH_RECV;
         desc_in.valid = 1'b1;
         desc_in.frame = 1'b1;
         desc_in.code  = sfrls_pkg::ST_OK;
         desc_in.addr  = address_ff;
         desc_in.ctrl  = control_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= sfrls_pkg::PH_IDLE;
         attempts_ff   <= 4'd0;
         ticks_ff      <= 8'd0;
         rxpos_ff      <= 3'd0;
         cap_ff[1]     <= 8'd0;
         cap_ff[2]     <= 8'd0;
         cap_ff[3]     <= 8'd0;
      end else begin
         phase_ff      <= phase_in;
         attempts_ff   <= attempts_in;
         ticks_ff      <= ticks_in;
         rxpos_ff      <= rxpos_in;
         cap_ff        <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_ff.valid <= 1'b0;
      end else begin
         desc_ff.valid <= desc_in.valid;
      end
      desc_ff.frame <= desc_in.frame;
      desc_ff.code  <= desc_in.code;
      desc_ff.addr  <= desc_in.addr;
      desc_ff.ctrl  <= desc_in.ctrl;
   end

   // result register: load a run, then advance one beat per handshake
   assign beat_nx = beat_ff + 3'd1;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_frame_in = out_frame_ff;
      beat_in      = beat_ff;
      tx_in        = tx_ff;
      code_in      = code_ff;
      last_in      = last_ff;
      oaddr_in     = oaddr_ff;
      octrl_in     = octrl_ff;
      if (desc_take) begin
         out_valid_in = 1'b1;
         out_frame_in = desc_ff.frame;
         beat_in      = 3'd0;
         tx_in        = desc_ff.frame ? sfrls_pkg::FRAME_FLAG : 8'd0;
         code_in      = desc_ff.frame ? sfrls_pkg::ST_OK : desc_ff.code;
         last_in      = !desc_ff.frame;
         oaddr_in     = desc_ff.addr;
         octrl_in     = desc_ff.ctrl;
      end else if (out_valid_ff && rsp_tready) begin
         if (last_ff) begin
            out_valid_in = 1'b0;
         end else begin
            beat_in = beat_nx;
            last_in = (beat_nx == sfrls_pkg::LAST_BEAT);
            unique case (beat_nx)
               3'd1:    tx_in = oaddr_ff;
               3'd2:    tx_in = octrl_ff;
               3'd3:    tx_in = oaddr_ff ^ octrl_ff;
               default: tx_in = sfrls_pkg::FRAME_FLAG;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_frame_ff <= out_frame_in;
      beat_ff      <= beat_in;
      tx_ff        <= tx_in;
      code_ff      <= code_in;
      last_ff      <= last_in;
      oaddr_ff     <= oaddr_in;
      octrl_ff     <= octrl_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, code_ff, tx_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = !out_frame_ff;

   // a status report is always a single beat with no byte
   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata[7:0] == 8'd0)
      else $error("status beat not single or carries a byte");

   // a frame closes on the flag byte
   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && rsp_tlast |-> rsp_tdata[7:0] == sfrls_pkg::FRAME_FLAG)
      else $error("frame does not end with a flag");

   // transmit beats carry no status code
   a_frame_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[9:8] == sfrls_pkg::ST_OK)
      else $error("transmit beat carries a status code");

   // a stalled frame beat holds its position in the run
   a_beat_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(beat_ff) && $stable(rsp_tlast))
      else $error("frame beat moved while stalled");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the SET-frame link set-up sender.
`timescale 1ns / 1ps

module tb;

   // request kind with no meaning; the block must ignore it
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic       okind;
      logic [5:0] pad;
      logic [1:0] code;
      logic [7:0] txb;
      logic       last;
   } link_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic [1:0]  req_tuser  = sfrls_pkg::KIND_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = sfrls_pkg::REG_TIMEOUT;
   logic [7:0]  csr_wdata  = 8'h00;

   set_frame_retry_link_setup DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // link state as the block should hold it
   logic [7:0] cfg_timeout = 8'd3;
   logic [3:0] cfg_max_att = 4'd3;
   logic [7:0] cfg_address = 8'd3;
   logic [7:0] cfg_control = 8'd3;
   sfrls_pkg::phase_type lk_phase = sfrls_pkg::PH_IDLE;
   logic [3:0] sent_count  = 4'd0;
   logic [7:0] ticks_left  = 8'd0;
   logic [2:0] rx_pos      = 3'd0;
   logic [7:0] rx_slot [4] = '{default: 8'h00};

   link_beat_type expected_beats[$];
   int mismatches      = 0;
   int effective_items = 0;
   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;

   function automatic void push_status(logic [1:0] code);
      expected_beats.push_back('{okind: 1'b1, pad: 6'd0, code: code, txb: 8'h00, last: 1'b1});
   endfunction

   function automatic void push_set_frame();
      logic [7:0] fr [5];
      fr = '{sfrls_pkg::FRAME_FLAG, cfg_address, cfg_control, cfg_address ^ cfg_control,
             sfrls_pkg::FRAME_FLAG};
      for (int k = 0; k < sfrls_pkg::FRAME_LEN; k++)
         expected_beats.push_back('{okind: 1'b0, pad: 6'd0, code: sfrls_pkg::ST_OK,
                                    txb: fr[k], last: (k == sfrls_pkg::FRAME_LEN - 1)});
      sent_count = sent_count + 4'd1;
      ticks_left = cfg_timeout;
      rx_pos     = 3'd0;
      rx_slot    = '{default: 8'h00};
      lk_phase   = sfrls_pkg::PH_RECV;
   endfunction

   // advance the link state by one event; return 1 when the event was not ignored
   function automatic bit link_predict(logic [1:0] kind, logic [7:0] rxb);
      case (kind)
         sfrls_pkg::KIND_START: begin
            sent_count = 4'd0;
            push_set_frame();
            return 1'b1;
         end
         sfrls_pkg::KIND_BYTE: begin
            if (lk_phase != sfrls_pkg::PH_RECV) return 1'b0;
            if (rxb == sfrls_pkg::FRAME_FLAG && rx_pos != 3'd0) begin
               if (rx_slot[3] == (rx_slot[1] ^ rx_slot[2])) begin
                  lk_phase = sfrls_pkg::PH_IDLE;
                  push_status(sfrls_pkg::ST_OK);
               end else begin
                  lk_phase = sfrls_pkg::PH_HOLD;
                  push_status(sfrls_pkg::ST_BAD_CHK);
               end
            end else begin
               if (rx_pos < 3'd4) rx_slot[rx_pos[1:0]] = rxb;
               if (rx_pos < sfrls_pkg::RX_FULL) rx_pos = rx_pos + 3'd1;
            end
            return 1'b1;
         end
         sfrls_pkg::KIND_TICK: begin
            if (lk_phase == sfrls_pkg::PH_IDLE) return 1'b0;
            if (ticks_left > 8'd1) begin
               ticks_left = ticks_left - 8'd1;
            end else begin
               ticks_left = 8'd0;
               if (sent_count < cfg_max_att) begin
                  push_set_frame();
               end else begin
                  lk_phase = sfrls_pkg::PH_IDLE;
                  push_status(sfrls_pkg::ST_GAVE_UP);
               end
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void flag_mismatch(string what, link_beat_type want, link_beat_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: expected k%0d b%02h c%0d l%0d p%02h, got k%0d b%02h c%0d l%0d p%02h",
                  $time, what, want.okind, want.txb, want.code, want.last, want.pad,
                  got.okind, got.txb, got.code, got.last, got.pad);
   endfunction

   // look at each result beat mid-cycle; it is taken at the next rising edge
   always @(negedge clock) begin
      link_beat_type got;
      link_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{okind: rsp_tuser, pad: rsp_tdata[15:10], code: rsp_tdata[9:8],
                 txb: rsp_tdata[7:0], last: rsp_tlast};
         if (expected_beats.size() == 0) begin
            flag_mismatch("result beat with none expected", '0, got);
         end else begin
            want = expected_beats.pop_front();
            if (got !== want) flag_mismatch("result beat differs", want, got);
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_item(input logic [1:0] kind, input logic [7:0] rxb);
      int gap;
      gap = 0;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 60) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= rxb;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      if (link_predict(kind, rxb)) effective_items++;
   endtask

   task automatic send_rx(input logic [7:0] b);
      send_item(sfrls_pkg::KIND_BYTE, b);
   endtask

   task automatic hold_until_quiet();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      // cover a request still in flight that yields nothing
      repeat (4) @(posedge clock);
   endtask

   task automatic set_link_regs(input logic [7:0] t, input logic [3:0] m,
                                input logic [7:0] a, input logic [7:0] c);
      csr_we    <= 1'b1;
      csr_index <= sfrls_pkg::REG_TIMEOUT;
      csr_wdata <= t;
      @(posedge clock);
      cfg_timeout = t;
      csr_index <= sfrls_pkg::REG_MAX_ATT;
      csr_wdata <= {4'd0, m};
      @(posedge clock);
      cfg_max_att = m;
      csr_index <= sfrls_pkg::REG_ADDRESS;
      csr_wdata <= a;
      @(posedge clock);
      cfg_address = a;
      csr_index <= sfrls_pkg::REG_CONTROL;
      csr_wdata <= c;
      @(posedge clock);
      cfg_control = c;
      csr_we <= 1'b0;
   endtask

   task automatic test_ignored_events();
      send_item(KIND_UNUSED, 8'hff);
      send_rx(sfrls_pkg::FRAME_FLAG);
      send_item(sfrls_pkg::KIND_TICK, 8'h00);
   endtask

   // bad check, byte dropped while holding, timeout resend, short response
   task automatic test_bad_check_retry();
      send_item(sfrls_pkg::KIND_START, 8'h00);
      send_rx(sfrls_pkg::FRAME_FLAG);
      send_rx(8'h01);
      send_rx(8'h02);
      send_rx(8'h00);
      send_rx(sfrls_pkg::FRAME_FLAG);
      send_rx(8'h55);
      repeat (3) send_item(sfrls_pkg::KIND_TICK, 8'haa);
      send_rx(sfrls_pkg::FRAME_FLAG);
      send_rx(sfrls_pkg::FRAME_FLAG);
   endtask

   // restart while busy, then a response with bytes past the fifth
   task automatic test_restart_overlong();
      send_item(sfrls_pkg::KIND_START, 8'h00);
      send_rx(sfrls_pkg::FRAME_FLAG);
      send_item(sfrls_pkg::KIND_START, 8'hff);
      send_rx(sfrls_pkg::FRAME_FLAG);
      send_rx(8'h11);
      send_rx(8'h22);
      send_rx(8'h33);
      send_rx(8'h44);
      send_rx(8'h55);
      send_rx(sfrls_pkg::FRAME_FLAG);
   endtask

   task automatic test_register_extremes();
      hold_until_quiet();
      // zero timeout and zero attempt limit: first tick gives up
      set_link_regs(8'd0, 4'd0, 8'hff, 8'h00);
      send_item(sfrls_pkg::KIND_START, 8'h00);
      send_item(sfrls_pkg::KIND_TICK, 8'h00);
      hold_until_quiet();
      set_link_regs(8'd1, 4'd2, 8'ha5, 8'h5a);
      send_item(sfrls_pkg::KIND_START, 8'h00);
      send_item(sfrls_pkg::KIND_TICK, 8'h00);
      send_item(sfrls_pkg::KIND_TICK, 8'h00);
   endtask

   task automatic random_session();
      logic [7:0] a, c;
      logic [7:0] resp [5];
      int mode, n;
      a    = 8'($urandom);
      c    = 8'($urandom);
      mode = $urandom_range(9);
      if (mode != 9) send_item(sfrls_pkg::KIND_START, 8'($urandom));
      case (mode)
         0, 1, 2, 3, 4, 5, 6: begin
            resp = '{sfrls_pkg::FRAME_FLAG, a, c, a ^ c, sfrls_pkg::FRAME_FLAG};
            if (mode >= 5) resp[3] = resp[3] ^ (8'd1 << $urandom_range(7));
            foreach (resp[k]) begin
               if ($urandom_range(7) == 0) send_item(sfrls_pkg::KIND_TICK, 8'($urandom));
               send_rx(resp[k]);
            end
            if (mode >= 5) begin
               n = $urandom_range(1, 8);
               repeat (n) send_item(sfrls_pkg::KIND_TICK, 8'($urandom));
            end
         end
         7: begin
            send_rx(sfrls_pkg::FRAME_FLAG);
            n = $urandom_range(4, 7);
            repeat (n) send_rx(8'($urandom_range(8'h7f, 8'hff)));
            send_rx(sfrls_pkg::FRAME_FLAG);
         end
         8: begin
            n = $urandom_range(1, 10);
            repeat (n) send_item(sfrls_pkg::KIND_TICK, 8'($urandom));
         end
         default: begin
            n = $urandom_range(1, 4);
            repeat (n) send_item(2'($urandom_range(3)), 8'($urandom));
         end
      endcase
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [7:0] t, input logic [3:0] m);
      int goal, sessions;
      hold_until_quiet();
      set_link_regs(t, m, 8'($urandom), 8'($urandom));
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      goal = effective_items + 30;
      sessions = 0;
      while (effective_items < goal) begin
         random_session();
         sessions++;
         if (sessions == 5) hold_until_quiet();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_ignored_events();
      test_bad_check_retry();
      test_restart_overlong();
      test_register_extremes();
      test_random_traffic(0, 0, 8'($urandom_range(1, 4)), 4'($urandom_range(1, 4)));
      test_random_traffic(88, 0, 8'($urandom_range(1, 4)), 4'($urandom_range(1, 4)));
      test_random_traffic(0, 88, 8'($urandom_range(1, 4)), 4'($urandom_range(1, 4)));
      test_random_traffic(17, 17, 8'd255, 4'd15);
      hold_until_quiet();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
